FILE: design/lsce_pkg.sv
// shared constants, types and helpers for the line sensor centroid block
// no dependencies; imported by lsce_ctrl, lsce_dp and line_sensor_centroid_ema
`default_nettype none

package lsce_pkg;

  localparam int LSCE_SENSOR_COUNT = 7;
  localparam int WEIGHT_W          = 8;
  localparam int FRAC_W            = 8;
  localparam int EMA_W             = 17;
  localparam int POS_W             = 8;
  localparam int ALPHA_W           = 9;
  localparam int CFG_IDX_W         = 2;

  localparam logic [63:0]        WEIGHT_RESET = 64'h001E_140A_00F6_ECE2;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 9'd154;
  localparam logic [ALPHA_W-1:0] ALPHA_FULL   = 9'd256;
  localparam int                 ROUND_HALF   = 128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLARITY = 2'd0,
    CFG_WEIGHTS  = 2'd1,
    CFG_ALPHA    = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIFF,
    ST_MULT,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic div_step;
    logic diff;
    logic mult;
    logic update;
    logic out_load;
  } lsce_cmd_t;

  typedef struct packed {
    logic count_zero;
  } lsce_status_t;

  // radix-4 divider steps needed for the scaled weight sum of n sensors
  function automatic int lsce_div_steps(input int n);
    return (WEIGHT_W + $clog2(n) + FRAC_W + 1) / 2;
  endfunction

endpackage

`default_nettype wire

FILE: design/lsce_ctrl.sv
// sequencer for the centroid block: handshakes, divide step count, ema steps
// depends on lsce_pkg; drives the command struct of lsce_dp
`default_nettype none

module lsce_ctrl #(
  parameter int SENSOR_COUNT = lsce_pkg::LSCE_SENSOR_COUNT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  input  wire lsce_pkg::lsce_status_t status,
  output lsce_pkg::lsce_cmd_t        cmd
);
  import lsce_pkg::*;

  localparam int DIV_STEPS = lsce_div_steps(SENSOR_COUNT);
  localparam int STEP_W    = $clog2(DIV_STEPS);

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          step_next   = '0;
          // no sensor on the line: average holds, go straight to output
          state_next  = status.count_zero ? ST_FINISH : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + STEP_W'(1);
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = ST_MULT;
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: design/lsce_dp.sv
// datapath: config registers, mask and weight sum, radix-4 divider, ema, output beat
// depends on lsce_pkg; sequenced by lsce_ctrl through lsce_cmd_t
`default_nettype none

module lsce_dp #(
  parameter int SENSOR_COUNT = lsce_pkg::LSCE_SENSOR_COUNT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire lsce_pkg::lsce_cmd_t                    cmd,
  output lsce_pkg::lsce_status_t                      status,
  input  wire logic [SENSOR_COUNT-1:0]                pin_levels,
  input  wire logic                                   cfg_write,
  input  wire logic [lsce_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [8*SENSOR_COUNT-1:0]              cfg_data,
  output logic [SENSOR_COUNT-1:0]                     line_mask,
  output logic [$clog2(SENSOR_COUNT+1)-1:0]           line_count,
  output logic                                        line_seen,
  output logic                                        line_full,
  output logic signed [lsce_pkg::POS_W-1:0]           position
);
  import lsce_pkg::*;

  localparam int CNT_W     = $clog2(SENSOR_COUNT + 1);
  localparam int WT_W      = WEIGHT_W * SENSOR_COUNT;
  localparam int SUM_W     = WEIGHT_W + $clog2(SENSOR_COUNT);
  localparam int DIV_STEPS = lsce_div_steps(SENSOR_COUNT);
  localparam int DVD_W     = 2 * DIV_STEPS;
  localparam int DIFF_W    = EMA_W + 1;
  localparam int PROD_W    = DIFF_W + ALPHA_W + 1;
  localparam int POSM_W    = EMA_W + 1;

  // configuration
  logic               polarity;
  logic [WT_W-1:0]    weights;
  logic [ALPHA_W-1:0] alpha;

  // item registers
  logic [SENSOR_COUNT-1:0]    mask_r;
  logic [CNT_W-1:0]           count_r;
  logic                       neg_r;
  logic [DVD_W-1:0]           dvd;
  logic [CNT_W-1:0]           rem;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod;
  logic signed [EMA_W-1:0]    ema;

  // combinational
  logic [SENSOR_COUNT-1:0]    mask_in;
  logic [CNT_W-1:0]           cnt_in;
  logic signed [SUM_W-1:0]    sum_in;
  logic [SUM_W-1:0]           mag_in;
  logic [CNT_W:0]             t1, t2;
  logic                       q1, q2;
  logic [CNT_W-1:0]           r1, r2;
  logic signed [DIFF_W-1:0]   q_mag, raw;
  logic [ALPHA_W-1:0]         alpha_sat;
  logic signed [PROD_W-1:0]   ema_sum;
  logic signed [POSM_W-1:0]   ema_x, pos_abs, pos_rnd, pos_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      polarity <= 1'b1;
      weights  <= WEIGHT_RESET[WT_W-1:0];
      alpha    <= ALPHA_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_POLARITY: polarity <= cfg_data[0];
        CFG_WEIGHTS:  weights  <= cfg_data[WT_W-1:0];
        CFG_ALPHA:    alpha    <= cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // mask, count and signed weight sum of the incoming beat
  always_comb begin
    mask_in = polarity ? pin_levels : ~pin_levels;
    cnt_in  = '0;
    sum_in  = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (mask_in[i]) begin
        cnt_in = cnt_in + CNT_W'(1);
        sum_in = sum_in + {{(SUM_W-WEIGHT_W){weights[WEIGHT_W*i+WEIGHT_W-1]}},
                           weights[WEIGHT_W*i +: WEIGHT_W]};
      end
    end
    mag_in = sum_in[SUM_W-1] ? SUM_W'(-sum_in) : SUM_W'(sum_in);
  end

  assign status.count_zero = (cnt_in == '0);

  // two restoring divide steps per cycle, remainder stays below the count
  always_comb begin
    t1 = {rem, dvd[DVD_W-1]};
    q1 = (t1 >= {1'b0, count_r});
    r1 = q1 ? CNT_W'(t1 - {1'b0, count_r}) : t1[CNT_W-1:0];
    t2 = {r1, dvd[DVD_W-2]};
    q2 = (t2 >= {1'b0, count_r});
    r2 = q2 ? CNT_W'(t2 - {1'b0, count_r}) : t2[CNT_W-1:0];
  end

  // truncation toward zero: divide the magnitude, then restore the sign
  assign q_mag     = signed'(DIFF_W'(dvd));
  assign raw       = neg_r ? -q_mag : q_mag;
  assign alpha_sat = (alpha > ALPHA_FULL) ? ALPHA_FULL : alpha;
  // ema + floor(a * (raw - ema) / 256) equals the weighted floor average
  assign ema_sum   = (prod >>> FRAC_W) + PROD_W'(ema);

  always_comb begin
    ema_x   = POSM_W'(ema);
    pos_abs = (ema > 0) ? ema_x : -ema_x;
    pos_rnd = (pos_abs + POSM_W'(ROUND_HALF)) >>> FRAC_W;
    pos_val = (ema > 0) ? pos_rnd : -pos_rnd;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mask_r  <= mask_in;
      count_r <= cnt_in;
      neg_r   <= sum_in[SUM_W-1];
      dvd     <= DVD_W'({mag_in, {FRAC_W{1'b0}}});
      rem     <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[DVD_W-3:0], q1, q2};
      rem <= r2;
    end
    if (cmd.diff) begin
      diff <= raw - DIFF_W'(ema);
    end
    if (cmd.mult) begin
      prod <= PROD_W'(signed'({1'b0, alpha_sat})) * PROD_W'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ema <= '0;
    end else if (cmd.update) begin
      ema <= ema_sum[EMA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      line_mask  <= mask_r;
      line_count <= count_r;
      line_seen  <= (count_r != '0);
      line_full  <= (count_r == CNT_W'(SENSOR_COUNT));
      position   <= pos_val[POS_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: design/line_sensor_centroid_ema.sv
// line sensor centroid with exponential smoothing: input beat is the raw pin
// levels, output beat is mask, count, found flags and smoothed position.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// Config is a plain write port (cfg_write, cfg_index, cfg_data): index 0
// polarity, 1 packed signed 8-bit weights, 2 alpha/256. The user must see that
// config is written only while idle; the block itself does not enforce this.
// With no sensor on the line the beat goes straight to the output load;
// otherwise it passes the radix-4 restoring divide of the weight sum by the
// count, then the difference, multiply and ema update steps. A new beat is
// taken the cycle after the result is loaded. The output register frees
// the input side: a new beat is accepted while the previous result waits.
// When out_stall holds, the block finishes the item and then waits to load it.
// Reset (rst, synchronous) restores the default config, zeroes the average
// and leaves no output beat pending.
// depends on lsce_pkg, lsce_ctrl, lsce_dp
`default_nettype none

module line_sensor_centroid_ema #(
  parameter int SENSOR_COUNT = lsce_pkg::LSCE_SENSOR_COUNT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [SENSOR_COUNT-1:0]         pin_levels,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [SENSOR_COUNT-1:0]              line_mask,
  output logic [$clog2(SENSOR_COUNT+1)-1:0]    line_count,
  output logic                                 line_seen,
  output logic                                 line_full,
  output logic signed [lsce_pkg::POS_W-1:0]    position,
  input  wire logic                            cfg_write,
  input  wire logic [lsce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [8*SENSOR_COUNT-1:0]       cfg_data
);
  import lsce_pkg::*;

  lsce_cmd_t    cmd;
  lsce_status_t status;

  lsce_ctrl #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lsce_dp #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .pin_levels (pin_levels),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .line_mask  (line_mask),
    .line_count (line_count),
    .line_seen  (line_seen),
    .line_full  (line_full),
    .position   (position)
  );

endmodule

`default_nettype wire
